// ===== hdl/sws_pkg.sv =====
// Package for the single-wire sensor readout block.
// Holds the sequencer phase type, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package sws_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_LOW     = 3'd2,
    PH_HIGH    = 3'd3,
    PH_WAIT    = 3'd4,
    PH_END_LOW = 3'd5,
    PH_RECOVER = 3'd6
  } phase_t;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 4'd3;

  localparam logic [CFG_DATA_W-1:0] SETTLE_RST   = 16'd4688;
  localparam logic [CFG_DATA_W-1:0] PULSE_RST    = 16'd15;
  localparam logic [CFG_DATA_W-1:0] WAIT_RST     = 16'd156;
  localparam logic [CFG_DATA_W-1:0] RECOVERY_RST = 16'd3125;

  // Longest run of empty phases that can be passed through in one tick.
  localparam int SKIP_STEPS = 6;

endpackage

// ===== hdl/sws_if.sv =====
// Channel interfaces of the single-wire sensor readout block.
// Input tick channel, result channel and configuration write channel.
// Depends on sws_pkg.
`timescale 1ns / 1ps

interface sws_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_sample;

  modport source (output valid, output start_req, output line_sample, input ready);
  modport sink (input valid, input start_req, input line_sample, output ready);
endinterface

interface sws_out_if #(
  parameter int OBJECT_BITS  = 17,
  parameter int AMBIENT_BITS = 14
);
  logic                    valid;
  logic                    ready;
  logic                    line_drive_enable;
  logic                    line_level;
  logic                    busy_res;
  logic                    done_res;
  logic [OBJECT_BITS-1:0]  object_value;
  logic [AMBIENT_BITS-1:0] ambient_value;

  modport source (output valid, output line_drive_enable, output line_level,
                  output busy_res, output done_res, output object_value,
                  output ambient_value, input ready);
  modport sink (input valid, input line_drive_enable, input line_level,
                input busy_res, input done_res, input object_value,
                input ambient_value, output ready);
endinterface

interface sws_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sws_pkg::CFG_IDX_W-1:0]   index;
  logic [sws_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sws_cfg_regs.sv =====
// Configuration register file holding the four phase lengths in ticks.
// Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_cfg_regs #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [sws_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0]  wr_data,
  output logic [DELAY_WIDTH-1:0]          settle_len,
  output logic [DELAY_WIDTH-1:0]          pulse_len,
  output logic [DELAY_WIDTH-1:0]          wait_len,
  output logic [DELAY_WIDTH-1:0]          recovery_len
);

  localparam logic [sws_pkg::CFG_DATA_W-1:0] WR_MASK =
    (DELAY_WIDTH >= sws_pkg::CFG_DATA_W) ? {sws_pkg::CFG_DATA_W{1'b1}} :
    sws_pkg::CFG_DATA_W'((32'd1 << DELAY_WIDTH) - 32'd1);

  logic [DELAY_WIDTH-1:0] settle_r, pulse_r, wait_r, recovery_r;
  logic [DELAY_WIDTH-1:0] wr_value;

  assign wr_value = DELAY_WIDTH'(wr_data & WR_MASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= DELAY_WIDTH'(sws_pkg::SETTLE_RST & WR_MASK);
      pulse_r    <= DELAY_WIDTH'(sws_pkg::PULSE_RST & WR_MASK);
      wait_r     <= DELAY_WIDTH'(sws_pkg::WAIT_RST & WR_MASK);
      recovery_r <= DELAY_WIDTH'(sws_pkg::RECOVERY_RST & WR_MASK);
    end else if (wr_en) begin
      unique case (wr_index)
        sws_pkg::CFG_SETTLE:   settle_r   <= wr_value;
        sws_pkg::CFG_PULSE:    pulse_r    <= wr_value;
        sws_pkg::CFG_WAIT:     wait_r     <= wr_value;
        sws_pkg::CFG_RECOVERY: recovery_r <= wr_value;
        default: ;
      endcase
    end
  end

  assign settle_len   = settle_r;
  assign pulse_len    = pulse_r;
  assign wait_len     = wait_r;
  assign recovery_len = recovery_r;

endmodule

// ===== hdl/sws_seq.sv =====
// Readout sequencer: phase, tick counter, bit counter and shift registers.
// Works out one tick's next state and result beat in a single pass.
// Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_seq #(
  parameter int OBJECT_BITS  = 17,
  parameter int AMBIENT_BITS = 14,
  parameter int DELAY_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                start_req,
  input  logic                                line_sample,
  input  logic [DELAY_WIDTH-1:0]              settle_len,
  input  logic [DELAY_WIDTH-1:0]              pulse_len,
  input  logic [DELAY_WIDTH-1:0]              wait_len,
  input  logic [DELAY_WIDTH-1:0]              recovery_len,
  output logic [4+OBJECT_BITS+AMBIENT_BITS-1:0] res_data
);

  localparam int TOTAL_BITS = OBJECT_BITS + AMBIENT_BITS;
  localparam int BI_W       = $clog2(TOTAL_BITS + 1);

  typedef struct packed {
    sws_pkg::phase_t         phase;
    logic [DELAY_WIDTH-1:0]  cnt;
    logic [BI_W-1:0]         bidx;
    logic [OBJECT_BITS-1:0]  obj;
    logic [AMBIENT_BITS-1:0] amb;
  } seq_st_t;

  seq_st_t                 st_r, st_nxt, s;
  logic                    hold_low_r, hold_low_nxt, hold_eval;
  logic [OBJECT_BITS-1:0]  obj_lat_r, obj_lat_nxt, obj_fin, obj_lat_eval;
  logic [AMBIENT_BITS-1:0] amb_lat_r, amb_lat_nxt, amb_fin, amb_lat_eval;
  logic                    run_skip, latch, bulk;
  logic [BI_W-1:0]         bulk_bi, n_obj, n_amb;
  logic [DELAY_WIDTH:0]    cnt_inc;
  logic                    drive, level;

  function automatic logic [DELAY_WIDTH-1:0] phase_len(sws_pkg::phase_t p,
      logic [DELAY_WIDTH-1:0] l_settle, logic [DELAY_WIDTH-1:0] l_pulse,
      logic [DELAY_WIDTH-1:0] l_wait, logic [DELAY_WIDTH-1:0] l_rec);
    logic [DELAY_WIDTH-1:0] len;
    unique case (p)
      sws_pkg::PH_SETTLE:  len = l_settle;
      sws_pkg::PH_LOW,
      sws_pkg::PH_HIGH,
      sws_pkg::PH_END_LOW: len = l_pulse;
      sws_pkg::PH_WAIT:    len = l_wait;
      sws_pkg::PH_RECOVER: len = l_rec;
      default:             len = '0;
    endcase
    return len;
  endfunction

  function automatic seq_st_t end_phase(seq_st_t cur, logic line);
    seq_st_t n;
    n     = cur;
    n.cnt = '0;
    unique case (cur.phase)
      sws_pkg::PH_SETTLE:  n.phase = sws_pkg::PH_LOW;
      sws_pkg::PH_LOW:     n.phase = sws_pkg::PH_HIGH;
      sws_pkg::PH_HIGH:    n.phase = sws_pkg::PH_WAIT;
      sws_pkg::PH_WAIT: begin
        if (cur.bidx < BI_W'(OBJECT_BITS)) begin
          n.obj = (cur.obj << 1) | OBJECT_BITS'(line);
        end else begin
          n.amb = (cur.amb << 1) | AMBIENT_BITS'(line);
        end
        n.bidx  = cur.bidx + 1'b1;
        n.phase = (n.bidx >= BI_W'(TOTAL_BITS)) ? sws_pkg::PH_END_LOW : sws_pkg::PH_LOW;
      end
      sws_pkg::PH_END_LOW: n.phase = sws_pkg::PH_RECOVER;
      sws_pkg::PH_RECOVER: begin
        n.phase = sws_pkg::PH_IDLE;
        n.bidx  = '0;
      end
      default:             n.phase = sws_pkg::PH_IDLE;
    endcase
    return n;
  endfunction

  always_comb begin
    s         = st_r;
    hold_eval = hold_low_r;
    run_skip  = 1'b0;
    latch     = 1'b0;
    bulk      = 1'b0;
    bulk_bi   = '0;
    cnt_inc   = {1'b0, st_r.cnt} + 1'b1;

    if (st_r.phase == sws_pkg::PH_IDLE) begin
      if (start_req) begin
        s.phase   = sws_pkg::PH_SETTLE;
        s.cnt     = '0;
        s.bidx    = '0;
        s.obj     = '0;
        s.amb     = '0;
        hold_eval = 1'b0;
        run_skip  = 1'b1;
      end
    end else if (cnt_inc >= {1'b0, phase_len(st_r.phase, settle_len, pulse_len,
                                             wait_len, recovery_len)}) begin
      if (st_r.phase == sws_pkg::PH_RECOVER) begin
        latch = 1'b1;
      end
      s        = end_phase(st_r, line_sample);
      run_skip = 1'b1;
    end else begin
      s.cnt = cnt_inc[DELAY_WIDTH-1:0];
    end

    // Phases of zero length end in the same tick. With zero pulse and wait
    // lengths every remaining bit takes this tick's line level at once.
    if (run_skip) begin
      for (int i = 0; i < sws_pkg::SKIP_STEPS; i++) begin
        if (s.phase != sws_pkg::PH_IDLE &&
            phase_len(s.phase, settle_len, pulse_len, wait_len, recovery_len) == '0) begin
          if (s.phase == sws_pkg::PH_WAIT && pulse_len == '0 && !bulk) begin
            bulk    = 1'b1;
            bulk_bi = s.bidx;
            s.bidx  = BI_W'(TOTAL_BITS);
            s.phase = sws_pkg::PH_END_LOW;
            s.cnt   = '0;
          end else begin
            if (s.phase == sws_pkg::PH_RECOVER) begin
              latch = 1'b1;
            end
            s = end_phase(s, line_sample);
          end
        end
      end
    end

    if (bulk_bi < BI_W'(OBJECT_BITS)) begin
      n_obj = BI_W'(OBJECT_BITS) - bulk_bi;
      n_amb = BI_W'(AMBIENT_BITS);
    end else begin
      n_obj = '0;
      n_amb = BI_W'(TOTAL_BITS) - bulk_bi;
    end

    if (!bulk) begin
      obj_fin = s.obj;
      amb_fin = s.amb;
    end else if (line_sample) begin
      obj_fin = ~((~s.obj) << n_obj);
      amb_fin = ~((~s.amb) << n_amb);
    end else begin
      obj_fin = s.obj << n_obj;
      amb_fin = s.amb << n_amb;
    end
    s.obj = obj_fin;
    s.amb = amb_fin;

    obj_lat_eval = latch ? obj_fin : obj_lat_r;
    amb_lat_eval = latch ? amb_fin : amb_lat_r;

    unique case (s.phase)
      sws_pkg::PH_IDLE: begin
        drive = hold_eval;
        level = 1'b0;
      end
      sws_pkg::PH_SETTLE,
      sws_pkg::PH_HIGH: begin
        drive = 1'b1;
        level = 1'b1;
      end
      sws_pkg::PH_LOW,
      sws_pkg::PH_END_LOW: begin
        drive = 1'b1;
        level = 1'b0;
      end
      default: begin
        drive = 1'b0;
        level = 1'b0;
      end
    endcase

    res_data = {drive, level, s.phase != sws_pkg::PH_IDLE, latch, obj_lat_eval, amb_lat_eval};

    st_nxt       = accept ? s : st_r;
    hold_low_nxt = accept ? hold_eval : hold_low_r;
    obj_lat_nxt  = accept ? obj_lat_eval : obj_lat_r;
    amb_lat_nxt  = accept ? amb_lat_eval : amb_lat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= sws_pkg::PH_IDLE;
      st_r.cnt   <= '0;
      st_r.bidx  <= '0;
      st_r.obj   <= '0;
      st_r.amb   <= '0;
      hold_low_r <= 1'b1;
      obj_lat_r  <= '0;
      amb_lat_r  <= '0;
    end else begin
      st_r       <= st_nxt;
      hold_low_r <= hold_low_nxt;
      obj_lat_r  <= obj_lat_nxt;
      amb_lat_r  <= amb_lat_nxt;
    end
  end

endmodule

// ===== hdl/sws_out_buf.sv =====
// Two-entry output buffer: a result register with a skid entry behind it.
// Keeps ticks flowing while the result side holds a beat back. No dependencies.
`timescale 1ns / 1ps

module sws_out_buf #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic             head_vld_r, head_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic [WIDTH-1:0] head_r, head_nxt, skid_r, skid_nxt;
  logic             push, pop;

  assign push_ready = !skid_vld_r;
  assign push       = push_valid && push_ready;
  assign pop        = head_vld_r && pop_ready;
  assign pop_valid  = head_vld_r;
  assign pop_data   = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        head_nxt = push_data;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_vld_r) begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== hdl/single_wire_sensor_readout_top.sv =====
// Single-wire sensor readout. Each input beat is one tick of the time base and
// gives exactly one result beat with the line drive, busy, done and the last
// latched values; a beat is taken whenever the buffer's skid entry is empty, and
// its result is registered there. The tick's whole phase step, including any
// run of zero-length phases, is worked out in one pass by the sequencer, and a
// two-entry output buffer lets the input keep flowing while the result side
// stalls for a beat. Configuration writes are taken at any time with no wait.
// Depends on sws_pkg, sws_if, sws_cfg_regs, sws_seq and sws_out_buf.
`timescale 1ns / 1ps

module single_wire_sensor_readout_top #(
  parameter int OBJECT_BITS  = 17,
  parameter int AMBIENT_BITS = 14,
  parameter int DELAY_WIDTH  = 16
) (
  input logic clk,
  input logic rst_n,
  sws_in_if.sink   in_ch,
  sws_out_if.source out_ch,
  sws_cfg_if.sink  cfg_ch
);

  localparam int RES_W = 4 + OBJECT_BITS + AMBIENT_BITS;

  logic [DELAY_WIDTH-1:0] settle_len, pulse_len, wait_len, recovery_len;
  logic [RES_W-1:0]       res_data, out_data;
  logic                   in_ready, accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;

  sws_cfg_regs #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_ch.valid),
    .wr_index     (cfg_ch.index),
    .wr_data      (cfg_ch.data),
    .settle_len   (settle_len),
    .pulse_len    (pulse_len),
    .wait_len     (wait_len),
    .recovery_len (recovery_len)
  );

  sws_seq #(
    .OBJECT_BITS  (OBJECT_BITS),
    .AMBIENT_BITS (AMBIENT_BITS),
    .DELAY_WIDTH  (DELAY_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .start_req    (in_ch.start_req),
    .line_sample  (in_ch.line_sample),
    .settle_len   (settle_len),
    .pulse_len    (pulse_len),
    .wait_len     (wait_len),
    .recovery_len (recovery_len),
    .res_data     (res_data)
  );

  sws_out_buf #(
    .WIDTH (RES_W)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ready),
    .push_data  (res_data),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_data)
  );

  assign out_ch.line_drive_enable = out_data[RES_W-1];
  assign out_ch.line_level        = out_data[RES_W-2];
  assign out_ch.busy_res          = out_data[RES_W-3];
  assign out_ch.done_res          = out_data[RES_W-4];
  assign out_ch.object_value      = out_data[AMBIENT_BITS +: OBJECT_BITS];
  assign out_ch.ambient_value     = out_data[AMBIENT_BITS-1:0];

endmodule
